FILE: design/slx_pkg.sv
// Shared types, constants and character-class helpers for the source lexer.
`default_nettype none

package slx_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CLS_W  = 3;
    localparam int POS_W  = 20;
    localparam int LINE_W = 20;
    localparam int LEN_W  = 16;
    localparam int KW_W   = 40;

    // Saturation limits
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

    // Request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Token classes
    localparam logic [CLS_W-1:0] CLS_PUNCT = 3'd0;
    localparam logic [CLS_W-1:0] CLS_INT   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_IDENT = 3'd2;
    localparam logic [CLS_W-1:0] CLS_IF    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_ELSE  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_WHILE = 3'd5;
    localparam logic [CLS_W-1:0] CLS_EOF   = 3'd6;

    // Characters
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

    // Keyword spellings, low byte is the last letter
    localparam logic [KW_W-1:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [KW_W-1:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [KW_W-1:0] KW_WHILE = 40'h77_6869_6C65;

    // One token
    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [BYTE_W-1:0] pbyte;
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
    } tok_t;

    // Tokens caused by one byte: one or two
    typedef struct packed {
        logic two;
        tok_t t0;
        tok_t t1;
    } rec_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ident(input logic [BYTE_W-1:0] b);
        is_ident = (b == CH_UNDER) || is_digit(b) ||
                   ((b >= 8'h61) && (b <= 8'h7A)) ||
                   ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        is_space = (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

FILE: design/slx_front.sv
// Front end: scanner state, byte classification and token building.
`default_nettype none

module slx_front
    import slx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] source_byte,
    output logic                   push,
    output rec_t                   push_data
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_INT     = 6'b000010,
        M_IDENT   = 6'b000100,
        M_SLASH   = 6'b001000,
        M_COMMENT = 6'b010000,
        M_DONE    = 6'b100000
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [POS_W-1:0]  pstart_reg, pstart_next;
    logic [LINE_W-1:0] pline_reg, pline_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [KW_W-1:0]   kw_reg, kw_next;

    logic cont;
    logic tok_a_v, tok_b_v;
    tok_t tok_a, tok_b;

    // Identifier class from length and the first five letters
    function automatic logic [CLS_W-1:0] ident_class(input logic [LEN_W-1:0] len,
                                                     input logic [KW_W-1:0] kw);
        if (len == LEN_W'(2) && kw == KW_IF)
            ident_class = CLS_IF;
        else if (len == LEN_W'(4) && kw == KW_ELSE)
            ident_class = CLS_ELSE;
        else if (len == LEN_W'(5) && kw == KW_WHILE)
            ident_class = CLS_WHILE;
        else
            ident_class = CLS_IDENT;
    endfunction

    // Next-state and token logic for one byte
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        plen_next   = plen_reg;
        kw_next     = kw_reg;
        cont        = 1'b0;
        tok_a_v     = 1'b0;
        tok_b_v     = 1'b0;
        tok_a       = '0;
        tok_b       = '0;

        if (accept && mode_reg != M_DONE) begin
            unique case (mode_reg)
                M_INT:     cont = is_digit(source_byte);
                M_IDENT:   cont = is_ident(source_byte);
                M_SLASH:   cont = (source_byte == CH_SLASH);
                M_COMMENT: cont = (source_byte != CH_NUL) && (source_byte != CH_NL);
                default:   cont = 1'b0;
            endcase

            if (cont) begin
                // Token or comment goes on
                if (mode_reg == M_SLASH) begin
                    mode_next = M_COMMENT;
                end else if (mode_reg == M_INT || mode_reg == M_IDENT) begin
                    if (plen_reg < LEN_W'(5))
                        kw_next = {kw_reg[KW_W-BYTE_W-1:0], source_byte};
                    if (plen_reg != LEN_MAX)
                        plen_next = plen_reg + LEN_W'(1);
                end
                pos_next = pos_reg + POS_W'(1);
            end else begin
                // Close the pending token
                tok_a.line  = pline_reg;
                tok_a.start = pstart_reg;
                tok_a.len   = plen_reg;
                unique case (mode_reg)
                    M_INT: begin
                        tok_a_v   = 1'b1;
                        tok_a.cls = CLS_INT;
                    end
                    M_IDENT: begin
                        tok_a_v   = 1'b1;
                        tok_a.cls = ident_class(plen_reg, kw_reg);
                    end
                    M_SLASH: begin
                        tok_a_v     = 1'b1;
                        tok_a.cls   = CLS_PUNCT;
                        tok_a.pbyte = CH_SLASH;
                        tok_a.len   = LEN_W'(1);
                    end
                    default: tok_a_v = 1'b0;
                endcase
                mode_next = M_IDLE;

                // Handle the byte from between tokens
                tok_b.line  = line_reg;
                tok_b.start = pos_reg;
                if (source_byte == CH_NUL) begin
                    tok_b_v   = 1'b1;
                    tok_b.cls = CLS_EOF;
                    mode_next = M_DONE;
                end else if (is_space(source_byte)) begin
                    if (source_byte == CH_NL && line_reg != LINE_MAX)
                        line_next = line_reg + LINE_W'(1);
                end else if (is_digit(source_byte) || is_ident(source_byte) ||
                             source_byte == CH_SLASH) begin
                    if (is_digit(source_byte))
                        mode_next = M_INT;
                    else if (is_ident(source_byte))
                        mode_next = M_IDENT;
                    else
                        mode_next = M_SLASH;
                    pstart_next = pos_reg;
                    pline_next  = line_reg;
                    plen_next   = LEN_W'(1);
                    kw_next     = KW_W'(source_byte);
                end else begin
                    tok_b_v     = 1'b1;
                    tok_b.cls   = CLS_PUNCT;
                    tok_b.pbyte = source_byte;
                    tok_b.len   = LEN_W'(1);
                end

                if (source_byte != CH_NUL)
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Pack the request for the queue
    always_comb begin
        push           = tok_a_v || tok_b_v;
        push_data.two  = tok_a_v && tok_b_v;
        push_data.t0   = tok_a_v ? tok_a : tok_b;
        push_data.t1   = tok_b;
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= LINE_W'(1);
            pstart_reg <= '0;
            pline_reg  <= LINE_W'(1);
            plen_reg   <= '0;
            kw_reg     <= '0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            plen_reg   <= plen_next;
            kw_reg     <= kw_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/slx_fifo.sv
// Short request queue between the front end and the output stage.
`default_nettype none

module slx_fifo
    import slx_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire rec_t push_data,
    output logic      full,
    input  wire logic pop,
    output rec_t      pop_data,
    output logic      empty
);

    rec_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   cnt_reg;

    assign full     = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (QAW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (QAW+1)'(1);
        end
    end

endmodule

`default_nettype wire

FILE: design/slx_back.sv
// Output stage: holds one request and hands out its tokens one at a time.
`default_nettype none

module slx_back
    import slx_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire rec_t               q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CLS_W-1:0]        m_token_class,
    output logic [BYTE_W-1:0]       m_punct_byte,
    output logic [LINE_W-1:0]       m_token_line,
    output logic [POS_W-1:0]        m_token_start,
    output logic [LEN_W-1:0]        m_token_length,
    output logic                    m_last_result
);

    rec_t rec_reg;
    logic valid_reg;
    logic idx_reg;
    logic is_last;
    tok_t cur;

    // Current token of the held request
    assign is_last = !rec_reg.two || idx_reg;
    assign cur     = idx_reg ? rec_reg.t1 : rec_reg.t0;
    assign q_pop   = !q_empty && (!valid_reg || (m_ready && is_last));

    assign m_valid        = valid_reg;
    assign m_token_class  = cur.cls;
    assign m_punct_byte   = cur.pbyte;
    assign m_token_line   = cur.line;
    assign m_token_start  = cur.start;
    assign m_token_length = cur.len;
    assign m_last_result  = is_last;

    // Payload register
    always_ff @(posedge aclk) begin
        if (q_pop)
            rec_reg <= q_data;
    end

    // Handout control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end else if (valid_reg && m_ready) begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: design/source_lexer_with_keywords_top.sv
// Streaming source lexer: one byte in per request, tokens out per request.
//
// Input channel (s_): one source byte per request; a zero byte ends the
// buffer and yields the end-of-file token, after which further bytes are
// taken and dropped until reset. Whitespace and line comments are skipped.
// Output channel (m_): one token per request with class, punctuation byte,
// line, start offset, length and a last flag on the final token of a byte.
// A byte yields zero, one or two tokens.
// Path: a token caused by a byte enters the queue when that byte is
// accepted, then the output register. Throughput: one byte per cycle
// while s_ready is high; a byte that yields two tokens holds the output
// for both, which the four-entry queue between scanner and output absorbs.
// Stall: when m_ready is low the token holds; the queue fills and s_ready
// drops only when all four entries are taken.
// Reset (aresetn, synchronous, active low) returns the scanner to line 1,
// offset 0 and empties the queue and output stage.
`default_nettype none

module source_lexer_with_keywords_top
    import slx_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [BYTE_W-1:0]  s_source_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CLS_W-1:0]        m_token_class,
    output logic [BYTE_W-1:0]       m_punct_byte,
    output logic [LINE_W-1:0]       m_token_line,
    output logic [POS_W-1:0]        m_token_start,
    output logic [LEN_W-1:0]        m_token_length,
    output logic                    m_last_result
);

    logic accept;
    logic push, full, pop, empty;
    rec_t push_data, pop_data;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    // Scanner
    slx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .source_byte (s_source_byte),
        .push        (push),
        .push_data   (push_data)
    );

    // Request queue
    slx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Output stage
    slx_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (empty),
        .q_data         (pop_data),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_class  (m_token_class),
        .m_punct_byte   (m_punct_byte),
        .m_token_line   (m_token_line),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_last_result  (m_last_result)
    );

endmodule

`default_nettype wire

FILE: design/slx_checker.sv
// Port-level checks for the source lexer, bound to the top level.
`default_nettype none

module slx_checker
    import slx_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [CLS_W-1:0]   m_token_class,
    input wire logic [BYTE_W-1:0]  m_punct_byte,
    input wire logic [LINE_W-1:0]  m_token_line,
    input wire logic [LEN_W-1:0]   m_token_length,
    input wire logic               m_last_result
);

    // A stalled token stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_class) &&
        $stable(m_token_length) && $stable(m_last_result))
        else $error("output token changed while stalled");

    // End of file is always the final token of its byte and has no length
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_class == CLS_EOF |-> m_last_result && m_token_length == '0)
        else $error("malformed end-of-file token");

    // Only punctuation carries a byte, and real tokens are never empty
    a_punct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_class != CLS_PUNCT && m_token_class != CLS_EOF |->
        m_punct_byte == '0 && m_token_length != '0)
        else $error("non-punctuation token with byte or zero length");

    // Lines count from one
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_line != '0)
        else $error("token on line zero");

endmodule

bind source_lexer_with_keywords_top slx_checker u_slx_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_class  (m_token_class),
    .m_punct_byte   (m_punct_byte),
    .m_token_line   (m_token_line),
    .m_token_length (m_token_length),
    .m_last_result  (m_last_result)
);

`default_nettype wire

FILE: bench/source_lexer_with_keywords_top_tb.sv
// Self-checking bench for the streaming source lexer: token predictor, scoreboard, stimulus.

module source_lexer_with_keywords_top_tb;
    import slx_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_INT, SCAN_WORD, SCAN_SLASH, SCAN_COMMENT, SCAN_DONE
    } scan_mode_t;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [BYTE_W-1:0] pbyte;
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              last;
    } token_rec_t;

    // Token predictor plus queue of tokens still owed by the block
    class token_tracker;
        scan_mode_t        mode;
        logic [POS_W-1:0]  offset;
        logic [LINE_W-1:0] line_no;
        logic [POS_W-1:0]  tok_start;
        logic [LINE_W-1:0] tok_line;
        logic [LEN_W-1:0]  tok_len;
        logic [KW_W-1:0]   spelling;
        token_rec_t        caused[$];
        token_rec_t        expected_tokens[$];
        int unsigned       errors;
        int unsigned       bytes_seen;
        int unsigned       tokens_seen;

        function new();
            mode        = SCAN_IDLE;
            offset      = '0;
            line_no     = LINE_W'(1);
            tok_start   = '0;
            tok_line    = LINE_W'(1);
            tok_len     = '0;
            spelling    = '0;
            errors      = 0;
            bytes_seen  = 0;
            tokens_seen = 0;
        endfunction

        static function bit digit_byte(logic [BYTE_W-1:0] b);
            return b >= "0" && b <= "9";
        endfunction

        static function bit word_byte(logic [BYTE_W-1:0] b);
            return b == CH_UNDER || digit_byte(b) || (b >= "a" && b <= "z") ||
                   (b >= "A" && b <= "Z");
        endfunction

        static function bit blank_byte(logic [BYTE_W-1:0] b);
            return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        function void add_token(logic [CLS_W-1:0] cls, logic [BYTE_W-1:0] pb,
                                logic [LINE_W-1:0] ln, logic [POS_W-1:0] st,
                                logic [LEN_W-1:0] len);
            token_rec_t t;
            t.cls   = cls;
            t.pbyte = pb;
            t.line  = ln;
            t.start = st;
            t.len   = len;
            t.last  = 1'b0;
            caused.push_back(t);
        endfunction

        // Keep the first five bytes for keyword matching; length saturates
        function void extend(logic [BYTE_W-1:0] b);
            if (tok_len < 5)
                spelling = {spelling[KW_W-BYTE_W-1:0], b};
            if (tok_len != LEN_MAX)
                tok_len++;
        endfunction

        function void start_token(scan_mode_t m, logic [BYTE_W-1:0] b);
            mode      = m;
            tok_start = offset;
            tok_line  = line_no;
            tok_len   = LEN_W'(1);
            spelling  = {{(KW_W-BYTE_W){1'b0}}, b};
        endfunction

        function logic [CLS_W-1:0] word_class();
            if (tok_len == 2 && spelling == KW_IF)    return CLS_IF;
            if (tok_len == 4 && spelling == KW_ELSE)  return CLS_ELSE;
            if (tok_len == 5 && spelling == KW_WHILE) return CLS_WHILE;
            return CLS_IDENT;
        endfunction

        // One accepted source byte: advance the scan and queue its tokens
        function void note_byte(logic [BYTE_W-1:0] b);
            bytes_seen++;
            if (mode == SCAN_DONE)
                return;
            caused.delete();
            case (mode)
                SCAN_INT: begin
                    if (digit_byte(b)) begin
                        extend(b);
                        offset++;
                        return;
                    end
                    add_token(CLS_INT, '0, tok_line, tok_start, tok_len);
                end
                SCAN_WORD: begin
                    if (word_byte(b)) begin
                        extend(b);
                        offset++;
                        return;
                    end
                    add_token(word_class(), '0, tok_line, tok_start, tok_len);
                end
                SCAN_SLASH: begin
                    if (b == CH_SLASH) begin
                        mode = SCAN_COMMENT;
                        offset++;
                        return;
                    end
                    add_token(CLS_PUNCT, CH_SLASH, tok_line, tok_start, LEN_W'(1));
                end
                SCAN_COMMENT: begin
                    if (b != CH_NUL && b != CH_NL) begin
                        offset++;
                        return;
                    end
                end
                default: ;
            endcase
            mode = SCAN_IDLE;

            if (b == CH_NUL) begin
                add_token(CLS_EOF, '0, line_no, offset, '0);
                mode = SCAN_DONE;
            end else if (blank_byte(b)) begin
                if (b == CH_NL && line_no != LINE_MAX)
                    line_no++;
            end else if (digit_byte(b)) begin
                start_token(SCAN_INT, b);
            end else if (word_byte(b)) begin
                start_token(SCAN_WORD, b);
            end else if (b == CH_SLASH) begin
                start_token(SCAN_SLASH, b);
            end else begin
                add_token(CLS_PUNCT, b, line_no, offset, LEN_W'(1));
            end

            if (mode != SCAN_DONE)
                offset++;
            if (caused.size() > 0)
                caused[caused.size()-1].last = 1'b1;
            foreach (caused[i])
                expected_tokens.push_back(caused[i]);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: token %0d %s expected %0h actual %0h",
                         $time, tokens_seen, name, want, got);
            end
        endfunction

        // One token taken from the block, checked against the oldest owed one
        function void check_token(logic [CLS_W-1:0] cls, logic [BYTE_W-1:0] pb,
                                  logic [LINE_W-1:0] ln, logic [POS_W-1:0] st,
                                  logic [LEN_W-1:0] len, logic last);
            token_rec_t want;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none, actual class %0h start %0h",
                         $time, cls, st);
                return;
            end
            want = expected_tokens.pop_front();
            tokens_seen++;
            compare("class", 32'(want.cls), 32'(cls));
            compare("punct_byte", 32'(want.pbyte), 32'(pb));
            compare("line", 32'(want.line), 32'(ln));
            compare("start", 32'(want.start), 32'(st));
            compare("length", 32'(want.len), 32'(len));
            compare("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_source_byte = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [CLS_W-1:0]   m_token_class;
    logic [BYTE_W-1:0]  m_punct_byte;
    logic [LINE_W-1:0]  m_token_line;
    logic [POS_W-1:0]   m_token_start;
    logic [LEN_W-1:0]   m_token_length;
    logic               m_last_result;

    int                 idle_pct   = 0;
    int                 stall_pct  = 0;
    int unsigned        bytes_sent = 0;
    token_tracker       tracker;

    string first_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string word_samples[17] = '{"if", "else", "while", "i", "el", "els", "whil", "iff",
                                "elses", "while_", "wHile", "IF", "_if", "else9",
                                "whilex", "w", "e"};

    source_lexer_with_keywords_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_byte  (s_source_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_class  (m_token_class),
        .m_punct_byte   (m_punct_byte),
        .m_token_line   (m_token_line),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_last_result  (m_last_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Token sink back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check tokens before noting the byte taken at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_token(m_token_class, m_punct_byte, m_token_line,
                                    m_token_start, m_token_length, m_last_result);
            if (s_valid && s_ready)
                tracker.note_byte(s_source_byte);
        end
    end

    // One request on the byte channel, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_source_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // One random piece of source text; pieces run together with no separator
    task automatic send_lexeme();
        int                kind;
        int                n;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(19);
        if (kind <= 3) begin
            n = ($urandom_range(39) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 1);
            send_byte(first_chars[$urandom_range(first_chars.len()-1)]);
            repeat (n - 1)
                send_byte(word_chars[$urandom_range(word_chars.len()-1)]);
        end else if (kind <= 6) begin
            send_text(word_samples[$urandom_range(16)]);
        end else if (kind <= 9) begin
            repeat ($urandom_range(10, 1))
                send_byte(BYTE_W'("0" + $urandom_range(9)));
        end else if (kind <= 12) begin
            repeat ($urandom_range(3, 1))
                send_byte(($urandom_range(2) == 0) ? CH_SPACE :
                          BYTE_W'(8'h09 + $urandom_range(4)));
        end else if (kind <= 14) begin
            do
                b = BYTE_W'($urandom_range(255, 1));
            while (token_tracker::word_byte(b) || token_tracker::blank_byte(b) ||
                   b == CH_SLASH);
            send_byte(b);
        end else if (kind == 15) begin
            send_text("//");
            repeat ($urandom_range(20)) begin
                do
                    b = BYTE_W'($urandom_range(255, 1));
                while (b == CH_NL);
                send_byte(b);
            end
            send_byte(CH_NL);
        end else if (kind == 16) begin
            send_byte(CH_SLASH);
        end else if (kind == 17) begin
            send_byte(CH_NL);
        end else begin
            send_byte(BYTE_W'($urandom_range(255, 1)));
        end
    endtask

    initial begin
        int unsigned phase_start;
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: keywords, near keyword, slash cases, cut tokens, high byte
        send_text("if else\nwhile_ 09/x;//c\n");
        send_byte(8'hFF);

        // Long integer cut by punctuation
        repeat (40)
            send_byte("7");
        send_byte(";");

        // Random text under four pacing mixes, draining between them
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 405)
                send_lexeme();
            s_valid <= 1'b0;
            @(posedge aclk);
            while (tracker.pending() != 0)
                @(posedge aclk);
        end

        // End of buffer from a random scan state, then bytes that must be dropped
        case ($urandom_range(4))
            0: send_text("tail_id");
            1: send_text("42");
            2: send_byte(CH_SLASH);
            3: send_text("// trailing");
            default: send_byte(CH_SPACE);
        endcase
        send_byte(CH_NUL);
        repeat (8)
            send_byte(BYTE_W'($urandom_range(255, 0)));
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Streamed %0d source bytes and checked %0d tokens under four pacing mixes.",
                 tracker.bytes_seen, tracker.tokens_seen);
        $display("Text mixed keywords, comments, held slashes, a long integer and post-EOF bytes.");
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
